// ===== rtl/sgar_pkg.sv =====
// ----------------------------------------------------------------------------
// sgar_pkg
// Shared constants, codes and types of the grouped aggregate-with-removal block.
// ----------------------------------------------------------------------------
package sgar_pkg;

  localparam int MAX_GROUPS = 64;
  localparam int MAX_SLOTS  = 64;
  localparam int DEPTH      = MAX_GROUPS * MAX_SLOTS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int RAW_ADDR_W = 14;

  localparam int CNT_W = 32;
  localparam int SUM_W = 48;
  localparam int SQ_W  = 63;
  localparam int RES_W = 64;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  localparam logic [1:0] ACC_COUNT  = 2'd0;
  localparam logic [1:0] ACC_SUM    = 2'd1;
  localparam logic [1:0] ACC_SUM_SQ = 2'd2;

  localparam logic [1:0] RD_COUNT  = 2'd0;
  localparam logic [1:0] RD_SUM    = 2'd1;
  localparam logic [1:0] RD_AVG    = 2'd2;
  localparam logic [1:0] RD_STDDEV = 2'd3;

  localparam logic [1:0] REG_ACC_KIND  = 2'd0;
  localparam logic [1:0] REG_READ_KIND = 2'd1;
  localparam logic [1:0] REG_IC        = 2'd2;

  localparam logic [RES_W-1:0] INT64_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] INT64_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        wr_sel;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
  } tbl_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
  } tbl_rsp_t;

  typedef struct packed {
    logic             start;
    logic             is_avg;
    logic [CNT_W-1:0] n;
    logic [SUM_W:0]   d;
    logic [SQ_W-1:0]  tsq;
    logic [SQ_W-1:0]  esq;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] result;
  } arith_rsp_t;

endpackage

// ===== rtl/sgar_in_if.sv =====
// ----------------------------------------------------------------------------
// sgar_in_if
// Input item channel: one accumulate or read request per item.
// ----------------------------------------------------------------------------
interface sgar_in_if import sgar_pkg::*;;
  logic             valid;
  logic             ready;
  logic             op;
  logic [5:0]       group;
  logic [5:0]       slot;
  logic [15:0]      sample;
  logic [CNT_W-1:0] grp_count;
  logic [SUM_W-1:0] grp_sum;
  logic [SQ_W-1:0]  grp_sum_sq;

  modport source (output valid, op, group, slot, sample, grp_count, grp_sum,
                  grp_sum_sq, input ready);
  modport sink (input valid, op, group, slot, sample, grp_count, grp_sum,
                grp_sum_sq, output ready);
endinterface

// ===== rtl/sgar_out_if.sv =====
// ----------------------------------------------------------------------------
// sgar_out_if
// Result item channel: one adjusted aggregate per read item.
// ----------------------------------------------------------------------------
interface sgar_out_if import sgar_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_value;
  logic             divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink (input valid, result_value, divide_by_zero, output ready);
endinterface

// ===== rtl/sparse_group_aggregate_removal.sv =====
// ----------------------------------------------------------------------------
// sparse_group_aggregate_removal
// Grouped count, sum and sum-of-squares tables with removal-adjusted reads.
// ----------------------------------------------------------------------------
// Items enter on in_ch (valid/ready). An accumulate item updates the table
// selected by accumulate_kind at group*intervention_count+slot and gives no
// result. A read item gives one result on out_ch: the supplied group totals
// minus the addressed entries, as count, sum, Q.16 average or Q.16 deviation.
// One item is worked on at a time. An accumulate reads the memory at accept
// and writes back in the cycle after, then the block takes the next item.
// A count or sum read passes through T_RD and T_OUT to the output register.
// An average runs the 128-step divider; a deviation runs three 64-step
// multiplies, the 128-step divide and a 64-step root. The next item is taken
// in the cycle after a read's result is loaded. After reset the block clears
// all 4096 table entries, one per cycle, and holds in_ch.ready low until the
// clearing is done. The user must write configuration only while no item
// is in flight; the block does not enforce this. A stalled result waits in
// the output register; the next item is accepted meanwhile, and a later read
// waits only if its result is ready before the earlier one has been taken.
// ----------------------------------------------------------------------------
module sparse_group_aggregate_removal import sgar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sgar_in_if.sink     in_ch,
  sgar_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [5:0] {
    T_CLEAR = 6'b000001,
    T_IDLE  = 6'b000010,
    T_ACC   = 6'b000100,
    T_RD    = 6'b001000,
    T_CALC  = 6'b010000,
    T_OUT   = 6'b100000
  } t_state_t;

  t_state_t         st_r;
  logic [1:0]       acc_kind_r;
  logic [1:0]       rd_kind_r;
  logic [6:0]       ic_r;
  logic             ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [15:0]      sample_r;
  logic [CNT_W-1:0] tc_r;
  logic [SUM_W-1:0] ts_r;
  logic [SQ_W-1:0]  tsq_r;
  logic [RES_W-1:0] res_r;
  logic             dz_r;
  logic             out_valid_r;
  logic [RES_W-1:0] out_val_r;
  logic             out_dz_r;

  logic [RAW_ADDR_W-1:0] raw_addr;
  logic             addr_ok;
  logic             in_acc;
  logic             clear_done;
  logic             cfg_wr;
  logic             out_load;
  tbl_req_t         treq;
  tbl_rsp_t         trsp;
  arith_req_t       areq;
  arith_rsp_t       arsp;
  logic [CNT_W-1:0] ent_cnt;
  logic [SUM_W-1:0] ent_sum;
  logic [SQ_W-1:0]  ent_sq;
  logic [CNT_W-1:0] rem_n;
  logic [SUM_W:0]   rem_d;
  logic signed [31:0] smp_ext;
  logic [31:0]      smp_sq;

  assign raw_addr = RAW_ADDR_W'(in_ch.group) * RAW_ADDR_W'(ic_r)
                  + RAW_ADDR_W'(in_ch.slot);
  assign addr_ok  = raw_addr < RAW_ADDR_W'(DEPTH);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == T_IDLE);

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ACC_KIND:  prdata = {30'd0, acc_kind_r};
      REG_READ_KIND: prdata = {30'd0, rd_kind_r};
      REG_IC:        prdata = {25'd0, ic_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_kind_r <= ACC_SUM;
      rd_kind_r  <= RD_COUNT;
      ic_r       <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ACC_KIND:  acc_kind_r <= pwdata[1:0];
        REG_READ_KIND: rd_kind_r  <= pwdata[1:0];
        REG_IC:        ic_r       <= pwdata[6:0];
        default:       ;
      endcase
    end
  end

  assign ent_cnt = ok_r ? trsp.cnt : '0;
  assign ent_sum = ok_r ? trsp.sum : '0;
  assign ent_sq  = ok_r ? trsp.sq  : '0;
  assign rem_n   = tc_r - ent_cnt;
  assign rem_d   = {ts_r[SUM_W-1], ts_r} - {ent_sum[SUM_W-1], ent_sum};
  assign smp_ext = {{16{sample_r[15]}}, sample_r};
  assign smp_sq  = smp_ext * smp_ext;

  always_comb begin
    treq        = '0;
    treq.rd_en  = in_acc && addr_ok;
    treq.addr   = in_acc ? raw_addr[ADDR_W-1:0] : addr_r;
    treq.wr_en  = (st_r == T_ACC) && ok_r;
    treq.cnt    = trsp.cnt + 1'b1;
    treq.sum    = trsp.sum + {{(SUM_W-16){sample_r[15]}}, sample_r};
    treq.sq     = trsp.sq + {31'd0, smp_sq};
    case (acc_kind_r)
      ACC_COUNT:  treq.wr_sel = 3'b001;
      ACC_SUM:    treq.wr_sel = 3'b010;
      ACC_SUM_SQ: treq.wr_sel = 3'b100;
      default:    treq.wr_sel = 3'b000;
    endcase
  end

  sgar_tables u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (treq),
    .rsp        (trsp),
    .clear_done (clear_done)
  );

  always_comb begin
    areq.start  = (st_r == T_RD) && (rd_kind_r == RD_AVG || rd_kind_r == RD_STDDEV)
                && (rem_n != '0);
    areq.is_avg = (rd_kind_r == RD_AVG);
    areq.n      = rem_n;
    areq.d      = rem_d;
    areq.tsq    = tsq_r;
    areq.esq    = ent_sq;
  end

  sgar_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign out_load = (st_r == T_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r     <= addr_ok;
      addr_r   <= raw_addr[ADDR_W-1:0];
      sample_r <= in_ch.sample;
      tc_r     <= in_ch.grp_count;
      ts_r     <= in_ch.grp_sum;
      tsq_r    <= in_ch.grp_sum_sq;
    end
    if (st_r == T_RD) begin
      dz_r <= 1'b0;
      unique case (rd_kind_r)
        RD_COUNT: res_r <= {32'd0, rem_n};
        RD_SUM:   res_r <= {{(RES_W-SUM_W-1){rem_d[SUM_W]}}, rem_d};
        default: begin
          res_r <= '0;
          dz_r  <= (rem_n == '0);
        end
      endcase
    end else if (st_r == T_CALC && arsp.done) begin
      res_r <= arsp.result;
    end
    if (out_load) begin
      out_val_r <= res_r;
      out_dz_r  <= dz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        T_CLEAR: if (clear_done) st_r <= T_IDLE;
        T_IDLE: begin
          if (in_acc) begin
            st_r <= (in_ch.op == OP_ACCUMULATE) ? T_ACC : T_RD;
          end
        end
        T_ACC:  st_r <= T_IDLE;
        T_RD:   st_r <= areq.start ? T_CALC : T_OUT;
        T_CALC: if (arsp.done) st_r <= T_OUT;
        T_OUT:  if (out_load) st_r <= T_IDLE;
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_val_r;
  assign out_ch.divide_by_zero = out_dz_r;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_done |-> !in_ch.ready)
    else $error("item accepted during table clearing");

  a_zero_on_divide_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_val_r == '0)
    else $error("divide-by-zero result carries a nonzero value");

  a_accumulate_writes_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.op == OP_ACCUMULATE |=> st_r == T_ACC ##1 st_r == T_IDLE)
    else $error("accumulate item did not write back in its slot");

  a_arith_only_when_calc: assert property (@(posedge clk) disable iff (!rst_n)
    arsp.done |-> st_r == T_CALC)
    else $error("arithmetic result outside the calculation state");

endmodule

// ===== rtl/sgar_tables.sv =====
// ----------------------------------------------------------------------------
// sgar_tables
// Count, sum and sum-of-squares memories with a registered read port and a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sgar_tables import sgar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output tbl_rsp_t rsp,
  output logic     clear_done
);

  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [SUM_W-1:0] sum_mem [DEPTH];
  logic [SQ_W-1:0]  sq_mem  [DEPTH];
  logic [ADDR_W:0]  clr_cnt_r;
  logic [ADDR_W:0]  clr_cnt_nxt;
  tbl_rsp_t         rsp_r;

  assign clear_done  = clr_cnt_r[ADDR_W];
  assign clr_cnt_nxt = clr_cnt_r + 1'b1;
  assign rsp         = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clear_done) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!clear_done) begin
      cnt_mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
      sum_mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
      sq_mem[clr_cnt_r[ADDR_W-1:0]]  <= '0;
    end else if (req.wr_en) begin
      if (req.wr_sel[0]) begin
        cnt_mem[req.addr] <= req.cnt;
      end
      if (req.wr_sel[1]) begin
        sum_mem[req.addr] <= req.sum;
      end
      if (req.wr_sel[2]) begin
        sq_mem[req.addr] <= req.sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp_r.cnt <= cnt_mem[req.addr];
      rsp_r.sum <= sum_mem[req.addr];
      rsp_r.sq  <= sq_mem[req.addr];
    end
  end

endmodule

// ===== rtl/sgar_arith.sv =====
// ----------------------------------------------------------------------------
// sgar_arith
// Sequential average and standard deviation unit: shift-add multiplier,
// restoring divider and digit-by-digit square root, one bit per cycle.
// ----------------------------------------------------------------------------
module sgar_arith import sgar_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV  = 5'b00100,
    A_SQRT = 5'b01000,
    A_DONE = 5'b10000
  } a_state_t;

  a_state_t         st_r;
  logic [1:0]       ph_r;
  logic [6:0]       cnt_r;
  logic             is_avg_r;
  logic             neg_r;
  logic [CNT_W-1:0] n_r;
  logic [SUM_W:0]   dm_r;
  logic [127:0]     acc_r;
  logic [127:0]     mcand_r;
  logic [63:0]      mplier_r;
  logic [95:0]      qn_r;
  logic [127:0]     x_r;
  logic [64:0]      rem_r;
  logic [63:0]      dvs_r;
  logic [65:0]      srem_r;
  logic [63:0]      root_r;
  logic [RES_W-1:0] res_r;

  logic [SUM_W:0]   d_mag;
  logic [127:0]     prod;
  logic [64:0]      rem_sh;
  logic             div_ge;
  logic [127:0]     quot;
  logic [66:0]      srem_sh;
  logic [66:0]      trial;
  logic             sq_ge;
  logic [63:0]      root_nxt;
  logic [95:0]      dd;
  logic [63:0]      q64;

  assign d_mag    = req.d[SUM_W] ? (~req.d + 1'b1) : req.d;
  assign prod     = acc_r + (mplier_r[0] ? mcand_r : 128'd0);
  assign rem_sh   = {rem_r[63:0], x_r[127]};
  assign div_ge   = rem_sh >= {1'b0, dvs_r};
  assign quot     = {x_r[126:0], div_ge};
  assign srem_sh  = {srem_r[64:0], x_r[127:126]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sq_ge    = srem_sh >= trial;
  assign root_nxt = {root_r[62:0], sq_ge};
  assign dd       = prod[95:0];
  assign q64      = quot[63:0];

  assign rsp.done   = (st_r == A_DONE);
  assign rsp.result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      unique case (st_r)
        A_IDLE: begin
          if (req.start) begin
            is_avg_r <= req.is_avg;
            neg_r    <= req.d[SUM_W];
            n_r      <= req.n;
            dm_r     <= d_mag;
            cnt_r    <= '0;
            rem_r    <= '0;
            if (req.is_avg) begin
              x_r   <= {64'd0, d_mag[SUM_W-1:0], 16'd0};
              dvs_r <= {32'd0, req.n};
              st_r  <= A_DIV;
            end else if (req.esq > req.tsq) begin
              res_r <= '0;
              st_r  <= A_DONE;
            end else begin
              mcand_r  <= {65'd0, req.tsq - req.esq};
              mplier_r <= {32'd0, req.n};
              acc_r    <= '0;
              ph_r     <= 2'd0;
              st_r     <= A_MUL;
            end
          end
        end
        A_MUL: begin
          acc_r    <= prod;
          mcand_r  <= {mcand_r[126:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[63:1]};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == 7'd63) begin
            cnt_r <= '0;
            acc_r <= '0;
            case (ph_r)
              2'd0: begin
                qn_r     <= prod[95:0];
                mcand_r  <= {79'd0, dm_r};
                mplier_r <= {15'd0, dm_r};
                ph_r     <= 2'd1;
              end
              2'd1: begin
                if (qn_r <= dd) begin
                  res_r <= '0;
                  st_r  <= A_DONE;
                end else begin
                  x_r      <= {qn_r - dd, 32'd0};
                  mcand_r  <= {96'd0, n_r};
                  mplier_r <= {32'd0, n_r};
                  ph_r     <= 2'd2;
                end
              end
              default: begin
                dvs_r <= prod[63:0];
                rem_r <= '0;
                st_r  <= A_DIV;
              end
            endcase
          end
        end
        A_DIV: begin
          rem_r <= div_ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
          x_r   <= quot;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'd127) begin
            cnt_r <= '0;
            if (is_avg_r) begin
              if (neg_r) begin
                res_r <= q64[63] ? INT64_MIN : (~q64 + 1'b1);
              end else begin
                res_r <= q64[63] ? INT64_MAX : q64;
              end
              st_r <= A_DONE;
            end else begin
              srem_r <= '0;
              root_r <= '0;
              st_r   <= A_SQRT;
            end
          end
        end
        A_SQRT: begin
          srem_r <= sq_ge ? 66'(srem_sh - trial) : srem_sh[65:0];
          root_r <= root_nxt;
          x_r    <= {x_r[125:0], 2'b00};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 7'd63) begin
            res_r <= root_nxt[63] ? INT64_MAX : root_nxt;
            st_r  <= A_DONE;
          end
        end
        A_DONE: begin
          st_r <= A_IDLE;
        end
        default: begin
          st_r <= A_IDLE;
        end
      endcase
    end
  end

endmodule
